@@ src/ssnf_pkg.sv @@
// ----------------------------------------------------------------------------
// ssnf_pkg - seven-segment number formatter shared definitions
// Field widths, format codes, glyph table and decimal divider constants.
// ----------------------------------------------------------------------------
package ssnf_pkg;

    localparam int MAG_W     = 24;  // width of the value word and its magnitude
    localparam int DIGITS    = 8;   // decimal digits of a 24-bit magnitude, also max cells
    localparam int DIG_IDX_W = 3;   // index into the digit row
    localparam int CNT_W     = 4;   // cell and digit counts, 0..DIGITS
    localparam int OUT_CELLS = 6;   // cells brought out to ports
    localparam int SEG_W     = 8;
    localparam int RECIP_W   = 25;  // reciprocal multiplier width for 24-bit dividends
    localparam int CFG_W     = 3;   // cells_in_use register width
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    typedef logic [SEG_W-1:0] t_seg;
    typedef logic [3:0]       t_digit;

    typedef enum logic [1:0] {
        KIND_DEC = 2'd0,
        KIND_HEX = 2'd1,
        KIND_FIX = 2'd2
    } t_kind;

    // Word index of the cells_in_use register (address bit 2).
    localparam logic REG_CELLS_IN_USE = 1'b0;

    localparam logic [CFG_W-1:0] CELLS_RESET = 3'd4;

    localparam t_seg SEG_MINUS = 8'h40;
    localparam t_seg SEG_POINT = 8'h80;

    localparam t_seg GLYPH [16] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
        8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71
    };

    localparam int unsigned POW10 [DIGITS] = '{
        1, 10, 100, 1000, 10000, 100000, 1000000, 10000000
    };

    // ceil(log2(10^k)): sets the shift of the reciprocal multiply.
    localparam int CLOG10 [DIGITS] = '{0, 4, 7, 10, 14, 17, 20, 24};

endpackage

@@ src/seven_segment_number_formatter.sv @@
// ----------------------------------------------------------------------------
// seven_segment_number_formatter - number to seven-segment cell patterns
// Signed decimal, hex and scaled decimal with point, right-aligned in a row
// of cells with an optional minus sign; cell 0 is the leftmost cell.
// ----------------------------------------------------------------------------
// Pipeline: an accepted word enters the input register and then moves to the
// result register, where o_valid goes high. Throughput: one word per cycle
// while not stalled; the slowest path is the magnitude negate, one 24x25
// reciprocal multiply, the digit count and the cell select into the glyph.
// Reset (synchronous, active low) empties both registers and sets
// cells_in_use to 4; no clearing pass.
module seven_segment_number_formatter #(
    parameter int MAX_CELLS = 6
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ssnf_pkg::ADDR_W-1:0]      paddr,
    input  logic [ssnf_pkg::DATA_W-1:0]      pwdata,
    output logic [ssnf_pkg::DATA_W-1:0]      prdata,
    output logic                             pready,
    // input words
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [1:0]                       i_kind,
    input  logic signed [ssnf_pkg::MAG_W-1:0] i_value,
    input  logic                             i_pad_zeros,
    input  logic [1:0]                       i_point_places,
    // result words
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [ssnf_pkg::SEG_W-1:0]       o_cell0,
    output logic [ssnf_pkg::SEG_W-1:0]       o_cell1,
    output logic [ssnf_pkg::SEG_W-1:0]       o_cell2,
    output logic [ssnf_pkg::SEG_W-1:0]       o_cell3,
    output logic [ssnf_pkg::SEG_W-1:0]       o_cell4,
    output logic [ssnf_pkg::SEG_W-1:0]       o_cell5
);

    localparam int MAG_W   = ssnf_pkg::MAG_W;
    localparam int DIGITS  = ssnf_pkg::DIGITS;
    localparam int CNT_W   = ssnf_pkg::CNT_W;
    localparam int RECIP_W = ssnf_pkg::RECIP_W;
    localparam int CFG_W   = ssnf_pkg::CFG_W;
    localparam int PROD_W  = MAG_W + RECIP_W;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]         r_cells_in_use;

    logic                     r_s1_valid;
    logic [1:0]               r_s1_kind;
    logic [MAG_W-1:0]         r_s1_value;
    logic                     r_s1_pad;
    logic [1:0]               r_s1_places;

    logic                     r_o_valid;
    ssnf_pkg::t_seg           r_out [ssnf_pkg::OUT_CELLS];

    // ------------------------------------------------------------------
    // Handshake: the result register advances when empty or taken, and
    // the input register refills whenever its word moves on.
    // ------------------------------------------------------------------
    logic out_adv;
    logic cfg_wr;

    assign out_adv = !r_o_valid || i_ready;
    assign o_ready = !r_s1_valid || out_adv;
    assign o_valid = r_o_valid;

    // APB: zero wait states; only word 0 holds a register.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == ssnf_pkg::REG_CELLS_IN_USE);
    assign prdata = (paddr[2] == ssnf_pkg::REG_CELLS_IN_USE)
                  ? {{(ssnf_pkg::DATA_W-CFG_W){1'b0}}, r_cells_in_use}
                  : '0;

    // ------------------------------------------------------------------
    // Fitted cell count: 0 acts as 1, anything above MAX_CELLS clamps.
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] s_n;

    always_comb begin
        if (r_cells_in_use == '0) begin
            s_n = CNT_W'(1);
        end else if ({1'b0, r_cells_in_use} > CNT_W'(MAX_CELLS)) begin
            s_n = CNT_W'(MAX_CELLS);
        end else begin
            s_n = {1'b0, r_cells_in_use};
        end
    end

    // ------------------------------------------------------------------
    // Decimal magnitude. The most negative value maps to 2^23, which
    // still fits the unsigned 24-bit magnitude.
    // ------------------------------------------------------------------
    logic             s_neg_in;
    logic [MAG_W-1:0] s_mag;

    assign s_neg_in = r_s1_value[MAG_W-1];
    assign s_mag    = s_neg_in ? (~r_s1_value + MAG_W'(1)) : r_s1_value;

    // Quotients by 10^k, all taken in parallel from the magnitude by
    // reciprocal multiplies (exact for every 24-bit dividend). Each digit
    // is then q[k] - 10*q[k+1], a short subtract in the low bits.
    logic [MAG_W-1:0]      s_quo     [DIGITS+1];
    ssnf_pkg::t_digit      s_dec_dig [DIGITS];
    ssnf_pkg::t_digit      s_hex_dig [DIGITS];

    assign s_quo[0]      = s_mag;
    assign s_quo[DIGITS] = '0;   // a 24-bit magnitude never reaches 10^8

    for (genvar k = 1; k < DIGITS; k++) begin : g_div
        localparam int SH = MAG_W + ssnf_pkg::CLOG10[k];
        localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(
            ((64'd1 << SH) + 64'(ssnf_pkg::POW10[k]) - 64'd1) / 64'(ssnf_pkg::POW10[k]));
        logic [PROD_W-1:0] prod;
        assign prod     = {{RECIP_W{1'b0}}, s_mag} * {{MAG_W{1'b0}}, RECIP};
        assign s_quo[k] = MAG_W'(prod >> SH);
    end

    for (genvar k = 0; k < DIGITS; k++) begin : g_dig
        logic [MAG_W-1:0] rem;
        assign rem          = s_quo[k] - ((s_quo[k+1] << 3) + (s_quo[k+1] << 1));
        assign s_dec_dig[k] = rem[3:0];
        if (k < 4) begin : g_hex
            assign s_hex_dig[k] = r_s1_value[4*k +: 4];
        end else begin : g_hex_zero
            assign s_hex_dig[k] = '0;
        end
    end

    // Significant digit counts (at least one digit, so zero shows "0").
    logic [CNT_W-1:0] s_nd_dec;
    logic [CNT_W-1:0] s_nd_hex;

    always_comb begin
        s_nd_dec = CNT_W'(1);
        for (int k = 1; k < DIGITS; k++) begin
            if (s_quo[k] != '0) begin
                s_nd_dec = CNT_W'(k + 1);
            end
        end
    end

    always_comb begin
        s_nd_hex = CNT_W'(1);
        for (int k = 1; k < 4; k++) begin
            if ((r_s1_value[15:0] >> (4 * k)) != 16'd0) begin
                s_nd_hex = CNT_W'(k + 1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Format select: digit row, sign, and how many digit cells to fill.
    // ------------------------------------------------------------------
    ssnf_pkg::t_digit s_dig [DIGITS];
    logic             s_known;
    logic             s_neg;
    logic             s_fix;
    logic [CNT_W-1:0] s_want;
    logic [CNT_W-1:0] s_need;
    logic [CNT_W-1:0] s_places_p1;

    assign s_places_p1 = CNT_W'(r_s1_places) + CNT_W'(1);

    always_comb begin
        s_dig   = s_dec_dig;
        s_known = 1'b1;
        s_neg   = 1'b0;
        s_fix   = 1'b0;
        s_want  = s_nd_dec;
        unique case (r_s1_kind)
            ssnf_pkg::KIND_DEC: begin
                s_neg  = s_neg_in;
                s_want = r_s1_pad ? s_n : s_nd_dec;
            end
            ssnf_pkg::KIND_HEX: begin
                s_dig  = s_hex_dig;
                s_want = r_s1_pad ? s_n : s_nd_hex;
            end
            ssnf_pkg::KIND_FIX: begin
                // keep a zero in front of the point; padding does not apply
                s_neg  = s_neg_in;
                s_fix  = 1'b1;
                s_want = (s_nd_dec < s_places_p1) ? s_places_p1 : s_nd_dec;
            end
            default: begin
                s_known = 1'b0;
            end
        endcase
        // drop the high digits that do not fit
        s_need = (s_want > s_n) ? s_n : s_want;
    end

    // ------------------------------------------------------------------
    // Cell assembly. Cell c holds digit n-1-c counted from the right; the
    // cell just past the last digit takes the minus sign if it is fitted.
    // ------------------------------------------------------------------
    ssnf_pkg::t_seg s_cell [MAX_CELLS];

    for (genvar c = 0; c < MAX_CELLS; c++) begin : g_cell
        logic [CNT_W-1:0] pos;
        assign pos = s_n - CNT_W'(c + 1);

        always_comb begin
            s_cell[c] = '0;
            if (s_known && (CNT_W'(c) < s_n)) begin
                if (pos < s_need) begin
                    s_cell[c] = ssnf_pkg::GLYPH[s_dig[pos[ssnf_pkg::DIG_IDX_W-1:0]]];
                    if (s_fix && (r_s1_places != 2'd0) && (pos == CNT_W'(r_s1_places))) begin
                        s_cell[c] = s_cell[c] | ssnf_pkg::SEG_POINT;
                    end
                end else if (s_neg && (pos == s_need)) begin
                    s_cell[c] = ssnf_pkg::SEG_MINUS;
                end
            end
        end
    end

    // Cells past MAX_CELLS stay dark.
    ssnf_pkg::t_seg s_out [ssnf_pkg::OUT_CELLS];

    for (genvar j = 0; j < ssnf_pkg::OUT_CELLS; j++) begin : g_out
        if (j < MAX_CELLS) begin : g_fit
            assign s_out[j] = s_cell[j];
        end else begin : g_dark
            assign s_out[j] = '0;
        end
    end

    // ------------------------------------------------------------------
    // Clocked state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells_in_use <= ssnf_pkg::CELLS_RESET;
            r_s1_valid     <= 1'b0;
            r_o_valid      <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_cells_in_use <= pwdata[CFG_W-1:0];
            end
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
            if (out_adv) begin
                r_o_valid <= r_s1_valid;
            end
        end
    end

    // Payload: load the input word on accept, the result when it advances.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_s1_kind   <= i_kind;
            r_s1_value  <= i_value;
            r_s1_pad    <= i_pad_zeros;
            r_s1_places <= i_point_places;
        end
        if (out_adv && r_s1_valid) begin
            r_out <= s_out;
        end
    end

    assign o_cell0 = r_out[0];
    assign o_cell1 = r_out[1];
    assign o_cell2 = r_out[2];
    assign o_cell3 = r_out[3];
    assign o_cell4 = r_out[4];
    assign o_cell5 = r_out[5];

endmodule

@@ src/ssnf_checker.sv @@
// ----------------------------------------------------------------------------
// ssnf_checker - port-level checks for the seven-segment number formatter
// Watches the result channel and the ready path across reset and stalls.
// ----------------------------------------------------------------------------
module ssnf_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_ready,
    input logic                             o_valid,
    input logic                             i_ready,
    input logic [ssnf_pkg::SEG_W-1:0]       o_cell0,
    input logic [ssnf_pkg::SEG_W-1:0]       o_cell1,
    input logic [ssnf_pkg::SEG_W-1:0]       o_cell2,
    input logic [ssnf_pkg::SEG_W-1:0]       o_cell3,
    input logic [ssnf_pkg::SEG_W-1:0]       o_cell4,
    input logic [ssnf_pkg::SEG_W-1:0]       o_cell5
);

    logic [6*ssnf_pkg::SEG_W-1:0] cells;
    logic [5:0]                   points;

    assign cells  = {o_cell5, o_cell4, o_cell3, o_cell2, o_cell1, o_cell0};
    assign points = {o_cell5[7], o_cell4[7], o_cell3[7], o_cell2[7], o_cell1[7], o_cell0[7]};

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(cells))
        else $error("result word changed while stalled");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // With the result register empty, the input side is never blocked.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty result register");

    // At most one decimal point is lit in any word.
    a_one_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $countones(points) <= 1)
        else $error("more than one decimal point lit");

endmodule

bind seven_segment_number_formatter ssnf_checker u_ssnf_checker (.*);
